FILE: hdl/bag_of_words_error_rate_assert.svh
// assertion macros shared by the bag_of_words_error_rate rtl
// no dependencies; the bodies vanish when SYNTHESIS is defined
`ifndef BAG_OF_WORDS_ERROR_RATE_ASSERT_SVH
`define BAG_OF_WORDS_ERROR_RATE_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define BOWER_ASSERT_SYNC(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bower assertion failed");
// condition in one cycle implies a result in the next
`define BOWER_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bower assertion failed");
`else
`define BOWER_ASSERT_SYNC(label, clk, rst, prop)
`define BOWER_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: hdl/bower_pkg.sv
// shared types and constants of the bag_of_words_error_rate block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bower_pkg;

   localparam int WordIdW = 24;
   localparam int OpW     = 2;
   localparam int CountW  = 8;
   localparam int AvgW    = 16;
   localparam int RefsW   = 5;
   localparam int FracW   = 8;
   localparam int FieldsW = 4 * CountW + AvgW + RefsW + 1;
   localparam int RspW    = 56;

   typedef enum logic [OpW-1:0] {
      OP_HYP = 2'd0,
      OP_REF = 2'd1,
      OP_END = 2'd2,
      OP_FIN = 2'd3
   } op_type;

   typedef struct packed {
      logic capture;
      logic set_ovf;
      logic ref_inc;
      logic addr_clr;
      logic addr_inc;
      logic mem_rd;
      logic compare;
      logic update;
      logic score;
      logic clr_wr;
      logic div_start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic hyp_full;
      logic ref_full;
      logic tab_empty;
      logic hit;
      logic scan_last;
      logic is_hyp;
      logic no_refs;
      logic div_done;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

FILE: hdl/bower_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module bower_div #(
   parameter int NUM_W = 26,
   parameter int DEN_W = 5
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);

   localparam int CntW = $clog2(NUM_W + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CntW'(NUM_W);
         rem_in = '0;
         quo_in = numer;
         den_in = denom;
      end else if (run_ff) begin
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

`default_nettype wire

FILE: hdl/bower_dp.sv
// datapath: word table memories, counters, scoring, divider and result register
// depends on bower_pkg, bower_div and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "bag_of_words_error_rate_assert.svh"

module bower_dp
   import bower_pkg::*;
#(
   parameter int MAX_LEN  = 128,
   parameter int MAX_REFS = 16,
   parameter int ID_BITS  = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [OpW-1:0]     req_op,
   input  wire logic [ID_BITS-1:0] req_id,
   input  wire cmd_type            cmd,
   output sts_type                 sts,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic [RspW-1:0]         rsp_data
);

   localparam int AddrW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CntW  = $clog2(MAX_LEN + 1);
   localparam int RefW  = $clog2(MAX_REFS + 1);
   localparam int TotW  = $clog2(MAX_LEN * MAX_REFS + 1);
   localparam int DivW  = TotW + FracW;
   localparam int RowW  = ID_BITS + CntW;

   function automatic logic [CountW-1:0] sat_count(input logic [31:0] v);
      sat_count = (v > 32'((1 << CountW) - 1)) ? '1 : v[CountW-1:0];
   endfunction

   // word table: id and hypothesis count per row, matched count alongside
   logic [RowW-1:0] tab_mem  [MAX_LEN];
   logic [CntW-1:0] used_mem [MAX_LEN];

   op_type             op_ff, op_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic               found_ff, found_in;
   logic [AddrW-1:0]   addr_ff, addr_in;
   logic [RowW-1:0]    tab_rd_ff;
   logic [CntW-1:0]    used_rd_ff;
   logic [CntW-1:0]    distinct_ff, distinct_in;
   logic [CntW-1:0]    hyp_len_ff, hyp_len_in;
   logic [CntW-1:0]    ref_len_ff, ref_len_in;
   logic [CntW-1:0]    match_ff, match_in;
   logic [CntW-1:0]    best_ins_ff, best_ins_in;
   logic [CntW-1:0]    best_del_ff, best_del_in;
   logic [CntW-1:0]    best_sub_ff, best_sub_in;
   logic [CntW-1:0]    best_score_ff, best_score_in;
   logic               best_valid_ff, best_valid_in;
   logic [TotW-1:0]    total_ff, total_in;
   logic [RefW-1:0]    ref_cnt_ff, ref_cnt_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RspW-1:0]    rsp_data_ff, rsp_data_in;

   logic [ID_BITS-1:0] rd_id;
   logic [CntW-1:0]    rd_cnt;
   logic               tab_we, used_we;
   logic [AddrW-1:0]   tab_wa, used_wa;
   logic [RowW-1:0]    tab_wd;
   logic [CntW-1:0]    used_wd;
   logic [AddrW-1:0]   new_addr;
   logic               op_hyp, can_match, refs_full;
   logic [CntW-1:0]    diff_i, diff_d;
   logic               i_gt_d, take;
   logic [CntW-1:0]    score, sub_v, ins_v, del_v;
   logic               div_done;
   logic [DivW-1:0]    quot;
   logic [AvgW-1:0]    avg;
   logic [RefsW-1:0]   refs_out;
   logic               out_free;

   assign rd_id     = tab_rd_ff[RowW-1:CntW];
   assign rd_cnt    = tab_rd_ff[CntW-1:0];
   assign new_addr  = distinct_ff[AddrW-1:0];
   assign op_hyp    = op_ff == OP_HYP;
   assign can_match = used_rd_ff < rd_cnt;
   assign refs_full = ref_cnt_ff >= RefW'(MAX_REFS);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // end of reference scoring
   assign diff_i = hyp_len_ff - match_ff;
   assign diff_d = ref_len_ff - match_ff;
   assign i_gt_d = diff_i > diff_d;
   assign score  = i_gt_d ? diff_i : diff_d;
   assign sub_v  = i_gt_d ? diff_d : diff_i;
   assign ins_v  = i_gt_d ? diff_i - diff_d : '0;
   assign del_v  = i_gt_d ? '0 : diff_d - diff_i;
   assign take   = !best_valid_ff || (score < best_score_ff);

   bower_div #(
      .NUM_W (DivW),
      .DEN_W (RefW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer ({total_ff, {FracW{1'b0}}}),
      .denom (ref_cnt_ff),
      .done  (div_done),
      .quot  (quot)
   );

   // table write ports
   always_comb begin
      tab_we  = cmd.update && op_hyp;
      tab_wa  = found_ff ? addr_ff : new_addr;
      tab_wd  = found_ff ? {rd_id, rd_cnt + CntW'(1)} : {id_ff, CntW'(1)};
      used_we = cmd.clr_wr ||
                (cmd.update && ((op_hyp && !found_ff) || (!op_hyp && can_match)));
      used_wa = (cmd.update && op_hyp) ? new_addr : addr_ff;
      used_wd = (cmd.update && !op_hyp) ? used_rd_ff + CntW'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_wa] <= tab_wd;
      end
      if (used_we) begin
         used_mem[used_wa] <= used_wd;
      end
      if (cmd.mem_rd) begin
         tab_rd_ff  <= tab_mem[addr_ff];
         used_rd_ff <= used_mem[addr_ff];
      end
   end

   assign avg = (ref_cnt_ff == '0) ? '0 :
                (32'(quot) > 32'((1 << AvgW) - 1)) ? '1 : AvgW'(quot);
   assign refs_out = (32'(ref_cnt_ff) > 32'((1 << RefsW) - 1)) ? '1 : RefsW'(ref_cnt_ff);

   always_comb begin
      op_in         = op_ff;
      id_in         = id_ff;
      found_in      = found_ff;
      addr_in       = addr_ff;
      distinct_in   = distinct_ff;
      hyp_len_in    = hyp_len_ff;
      ref_len_in    = ref_len_ff;
      match_in      = match_ff;
      best_ins_in   = best_ins_ff;
      best_del_in   = best_del_ff;
      best_sub_in   = best_sub_ff;
      best_score_in = best_score_ff;
      best_valid_in = best_valid_ff;
      total_in      = total_ff;
      ref_cnt_in    = ref_cnt_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      if (cmd.capture) begin
         op_in    = op_type'(req_op);
         id_in    = req_id;
         found_in = 1'b0;
      end
      if (cmd.compare && sts.hit) begin
         found_in = 1'b1;
      end
      if (cmd.addr_clr) begin
         addr_in = '0;
      end else if (cmd.addr_inc) begin
         addr_in = addr_ff + AddrW'(1);
      end
      if (cmd.set_ovf) begin
         ovf_in = 1'b1;
      end
      if (cmd.ref_inc) begin
         ref_len_in = ref_len_ff + CntW'(1);
      end
      if (cmd.update) begin
         if (op_hyp) begin
            hyp_len_in = hyp_len_ff + CntW'(1);
            if (!found_ff) begin
               distinct_in = distinct_ff + CntW'(1);
            end
         end else if (can_match) begin
            match_in = match_ff + CntW'(1);
         end
      end
      if (cmd.score) begin
         ref_len_in = '0;
         match_in   = '0;
         if (refs_full) begin
            ovf_in = 1'b1;
         end else begin
            if (take) begin
               best_valid_in = 1'b1;
               best_score_in = score;
               best_ins_in   = ins_v;
               best_del_in   = del_v;
               best_sub_in   = sub_v;
            end
            total_in   = total_ff + TotW'(ref_len_ff);
            ref_cnt_in = ref_cnt_ff + RefW'(1);
         end
      end
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = {{(RspW - FieldsW){1'b0}}, ovf_ff, refs_out, avg,
                          sat_count(32'(best_score_ff)), sat_count(32'(best_sub_ff)),
                          sat_count(32'(best_del_ff)), sat_count(32'(best_ins_ff))};
         distinct_in   = '0;
         hyp_len_in    = '0;
         ref_len_in    = '0;
         match_in      = '0;
         best_ins_in   = '0;
         best_del_in   = '0;
         best_sub_in   = '0;
         best_score_in = '0;
         best_valid_in = 1'b0;
         total_in      = '0;
         ref_cnt_in    = '0;
         ovf_in        = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         distinct_ff   <= '0;
         hyp_len_ff    <= '0;
         ref_len_ff    <= '0;
         match_ff      <= '0;
         best_ins_ff   <= '0;
         best_del_ff   <= '0;
         best_sub_ff   <= '0;
         best_score_ff <= '0;
         best_valid_ff <= 1'b0;
         total_ff      <= '0;
         ref_cnt_ff    <= '0;
         ovf_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
      end else begin
         distinct_ff   <= distinct_in;
         hyp_len_ff    <= hyp_len_in;
         ref_len_ff    <= ref_len_in;
         match_ff      <= match_in;
         best_ins_ff   <= best_ins_in;
         best_del_ff   <= best_del_in;
         best_sub_ff   <= best_sub_in;
         best_score_ff <= best_score_in;
         best_valid_ff <= best_valid_in;
         total_ff      <= total_in;
         ref_cnt_ff    <= ref_cnt_in;
         ovf_ff        <= ovf_in;
         rsp_valid_ff  <= rsp_valid_in;
         found_ff      <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      id_ff       <= id_in;
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      sts           = '0;
      sts.hyp_full  = hyp_len_ff >= CntW'(MAX_LEN);
      sts.ref_full  = ref_len_ff >= CntW'(MAX_LEN);
      sts.tab_empty = distinct_ff == '0;
      sts.hit       = rd_id == id_ff;
      sts.scan_last = CntW'(addr_ff) == distinct_ff - CntW'(1);
      sts.is_hyp    = op_hyp;
      sts.no_refs   = ref_cnt_ff == '0;
      sts.div_done  = div_done;
      sts.out_free  = out_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `BOWER_ASSERT_SYNC(a_match_le_ref, clock, reset, match_ff <= ref_len_ff)
   `BOWER_ASSERT_SYNC(a_distinct_le_hyp, clock, reset, distinct_ff <= hyp_len_ff)
   `BOWER_ASSERT_SYNC(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.emit))
   `BOWER_ASSERT_NEXT(a_score_clears, clock, reset, cmd.score, ref_len_ff == '0 && match_ff == '0)

endmodule

`default_nettype wire

FILE: hdl/bower_ctrl.sv
// controller: sequences table scans, updates, scoring, clearing and finish
// depends on bower_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "bag_of_words_error_rate_assert.svh"

module bower_ctrl
   import bower_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic [OpW-1:0] req_op,
   output logic                req_ready,
   output cmd_type             cmd,
   input  wire sts_type        sts
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_READ  = 8'b0000_0010,
      S_CMP   = 8'b0000_0100,
      S_UPD   = 8'b0000_1000,
      S_SCORE = 8'b0001_0000,
      S_CLEAR = 8'b0010_0000,
      S_DIV   = 8'b0100_0000,
      S_EMIT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               unique case (op_type'(req_op))
                  OP_HYP: begin
                     if (sts.hyp_full) begin
                        cmd.set_ovf = 1'b1;
                     end else begin
                        cmd.addr_clr = 1'b1;
                        state_in     = sts.tab_empty ? S_UPD : S_READ;
                     end
                  end
                  OP_REF: begin
                     if (sts.ref_full) begin
                        cmd.set_ovf = 1'b1;
                     end else begin
                        cmd.ref_inc  = 1'b1;
                        cmd.addr_clr = 1'b1;
                        state_in     = sts.tab_empty ? S_IDLE : S_READ;
                     end
                  end
                  OP_END: begin
                     state_in = S_SCORE;
                  end
                  OP_FIN: begin
                     if (sts.no_refs) begin
                        state_in = S_EMIT;
                     end else begin
                        cmd.div_start = 1'b1;
                        state_in      = S_DIV;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_CMP;
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            priority if (sts.hit) begin
               state_in = S_UPD;
            end else if (sts.scan_last) begin
               // miss: a hypothesis word goes in as a new row
               state_in = sts.is_hyp ? S_UPD : S_IDLE;
            end else begin
               cmd.addr_inc = 1'b1;
               state_in     = S_READ;
            end
         end
         S_UPD: begin
            cmd.update = 1'b1;
            state_in   = S_IDLE;
         end
         S_SCORE: begin
            cmd.score    = 1'b1;
            cmd.addr_clr = 1'b1;
            state_in     = sts.tab_empty ? S_IDLE : S_CLEAR;
         end
         S_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.scan_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.addr_inc = 1'b1;
            end
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BOWER_ASSERT_SYNC(a_cmp_after_read, clock, reset,
                      (state_ff == S_CMP) |-> $past(state_ff == S_READ))
   `BOWER_ASSERT_SYNC(a_div_has_refs, clock, reset, cmd.div_start |-> !sts.no_refs)
   `BOWER_ASSERT_SYNC(a_state_onehot, clock, reset, $onehot(state_ff))

endmodule

`default_nettype wire

FILE: hdl/bag_of_words_error_rate.sv
// top level of the position independent error rate scorer
// depends on bower_pkg, bower_ctrl and bower_dp
//
//   channel   dir   tdata (low bit up)                          tuser
//   req_      in    word_id[23:0]                               op[1:0]
//   rsp_      out   insertions, deletions, substitutions,       -
//                   error_score, avg_ref_len_q8, refs_used,
//                   overflow, 2 zero pad bits
//
// per word: accepted in the idle state, then a read and a compare state per table row
//   scanned and an update state on a hit or a new row (single port table read)
// end of reference: score, then a clear pass over the distinct rows' matched counts
// finish: divide, one quotient bit per cycle, then emit; with no reference no divide
// reset: synchronous, active high; no clearing pass, the table is valid by fill count
// stalls: a result waits in the output register; the next finish holds until it drains
`timescale 1ns / 1ps
`default_nettype none

module bag_of_words_error_rate
   import bower_pkg::*;
#(
   parameter int MAX_LEN      = 128,
   parameter int MAX_REFS     = 16,
   parameter int WORD_ID_BITS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [WordIdW-1:0] req_tdata,  // word_id[23:0]
   input  wire logic [OpW-1:0]     req_tuser,  // op[1:0]
   // response channel
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [RspW-1:0]         rsp_tdata   // ins[7:0], del[15:8], sub[23:16],
                                               // score[31:24], avg[47:32],
                                               // refs[52:48], overflow[53]
);

   // only the low id bits take part in the compare
   localparam int IdBits = (WORD_ID_BITS < WordIdW) ? WORD_ID_BITS : WordIdW;

   cmd_type cmd;
   sts_type sts;

   // sequencing lives in the controller, all storage in the datapath
   bower_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_ready (req_tready),
      .cmd       (cmd),
      .sts       (sts)
   );

   bower_dp #(
      .MAX_LEN  (MAX_LEN),
      .MAX_REFS (MAX_REFS),
      .ID_BITS  (IdBits)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_op    (req_tuser),
      .req_id    (req_tdata[IdBits-1:0]),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_data  (rsp_tdata)
   );

endmodule

`default_nettype wire
